// ===== src/packed_sample_unpack_channel_sum_unit_defines.svh =====
// Assertion macros for the checker file of this block.
`ifndef PACKED_SAMPLE_UNPACK_CHANNEL_SUM_UNIT_DEFINES_SVH
`define PACKED_SAMPLE_UNPACK_CHANNEL_SUM_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define PSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define PSU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/psu_pkg.sv =====
package psu_pkg;

  // Channel limit and derived widths.
  localparam int MAX_CHANNELS = 4096;
  localparam int CH_W         = 13;
  localparam int SEEN_W       = $clog2(MAX_CHANNELS + 8);
  localparam int SUM_W        = 20;
  localparam int ADD_W        = 8;
  localparam int CNT_W        = 4;
  localparam int CFG_IDX_W    = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd1;

  // Sample width codes.
  localparam logic [1:0] WIDTH_1BIT = 2'd0;
  localparam logic [1:0] WIDTH_2BIT = 2'd1;
  localparam logic [1:0] WIDTH_4BIT = 2'd2;
  localparam logic [1:0] WIDTH_8BIT = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [1:0]      SAMPLE_WIDTH_RESET  = WIDTH_8BIT;
  localparam logic [CH_W-1:0] CHANNEL_COUNT_RESET = CH_W'(1024);

  // Unpacked samples of one byte, with count and sample total.
  typedef struct packed {
    logic [7:0]       s0;
    logic [3:0]       s1;
    logic [1:0]       s2;
    logic [1:0]       s3;
    logic             s4;
    logic             s5;
    logic             s6;
    logic             s7;
    logic [CNT_W-1:0] count;
    logic [ADD_W-1:0] add;
  } unpack_t;

endpackage

// ===== src/psu_unpack.sv =====
module psu_unpack (
  input  logic [7:0]       data_byte,
  input  logic [1:0]       sample_width,
  output psu_pkg::unpack_t unpacked
);
  import psu_pkg::*;

  unpack_t u;

  // Split the byte by sample width, most significant field first.
  always_comb begin
    u = '0;
    case (sample_width)
      WIDTH_1BIT: begin
        u.s0    = {7'd0, ~data_byte[7]};
        u.s1    = {3'd0, ~data_byte[6]};
        u.s2    = {1'b0, ~data_byte[5]};
        u.s3    = {1'b0, ~data_byte[4]};
        u.s4    = ~data_byte[3];
        u.s5    = ~data_byte[2];
        u.s6    = ~data_byte[1];
        u.s7    = ~data_byte[0];
        u.count = CNT_W'(8);
      end
      WIDTH_2BIT: begin
        u.s0    = {6'd0, data_byte[7:6]};
        u.s1    = {2'd0, data_byte[5:4]};
        u.s2    = data_byte[3:2];
        u.s3    = data_byte[1:0];
        u.count = CNT_W'(4);
      end
      WIDTH_4BIT: begin
        u.s0    = {4'd0, data_byte[7:4]};
        u.s1    = data_byte[3:0];
        u.count = CNT_W'(2);
      end
      default: begin
        u.s0    = data_byte;
        u.count = CNT_W'(1);
      end
    endcase
    // Unused fields are zero, so a plain total of all eight is exact.
    u.add = u.s0 + ADD_W'(u.s1) + ADD_W'(u.s2) + ADD_W'(u.s3)
          + ADD_W'(u.s4) + ADD_W'(u.s5) + ADD_W'(u.s6) + ADD_W'(u.s7);
  end

  assign unpacked = u;

endmodule

// ===== src/psu_accum.sv =====
module psu_accum (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  psu_pkg::unpack_t          unpacked,
  input  logic [psu_pkg::CH_W-1:0]  channel_count,
  output logic [psu_pkg::SUM_W-1:0] spectrum_sum,
  output logic                      sum_done
);
  import psu_pkg::*;

  logic [SUM_W-1:0]  running_sum;
  logic [SEEN_W-1:0] samples_seen;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_sat;
  logic [SEEN_W-1:0] seen_next;
  logic [CH_W-1:0]   limit;

  // Saturating sum and sample count including the current byte.
  always_comb begin
    sum_wide  = {1'b0, running_sum} + (SUM_W + 1)'(unpacked.add);
    sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    seen_next = samples_seen + SEEN_W'(unpacked.count);
    limit     = (channel_count > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS)
                                                     : channel_count;
    sum_done  = (CH_W'(seen_next) >= limit);
  end

  assign spectrum_sum = sum_done ? sum_sat : '0;

  // The byte that ends a spectrum clears the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      samples_seen <= '0;
    end else if (take) begin
      if (sum_done) begin
        running_sum  <= '0;
        samples_seen <= '0;
      end else begin
        running_sum  <= sum_sat;
        samples_seen <= seen_next;
      end
    end
  end

endmodule

// ===== src/packed_sample_unpack_channel_sum_unit.sv =====
// Channel  Handshake              Payload
// input    in_valid / in_ready    data_byte
// output   out_valid / out_ready  sample_0..sample_7, sample_count, spectrum_sum, sum_ready
// config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while the output is not stalled; a byte passes through the input
// register and then the result register, with the unpack, sample adder and saturating
// accumulator in between.
// Synchronous active-high reset clears the pipeline, the running sum and the
// sample count, and loads 8-bit samples and 1024 channels.
// A stalled output holds its beat; the input register keeps accepting
// as long as the result register is empty or being drained.
module packed_sample_unpack_channel_sum_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    sample_0,
  output logic [3:0]                    sample_1,
  output logic [1:0]                    sample_2,
  output logic [1:0]                    sample_3,
  output logic                          sample_4,
  output logic                          sample_5,
  output logic                          sample_6,
  output logic                          sample_7,
  output logic [psu_pkg::CNT_W-1:0]     sample_count,
  output logic [psu_pkg::SUM_W-1:0]     spectrum_sum,
  output logic                          sum_ready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psu_pkg::CH_W-1:0]      cfg_data
);
  import psu_pkg::*;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_advance;
  logic [1:0]       sample_width;
  logic [CH_W-1:0]  chan_count;
  unpack_t          unpacked;
  logic [SUM_W-1:0] sum_value;
  logic             sum_done;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_width <= SAMPLE_WIDTH_RESET;
      chan_count   <= CHANNEL_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SAMPLE_WIDTH:  sample_width <= cfg_data[1:0];
        REG_CHANNEL_COUNT: chan_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register moves forward when the result register is free.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
    end
  end

  psu_unpack u_unpack (
    .data_byte    (s1_byte),
    .sample_width (sample_width),
    .unpacked     (unpacked)
  );

  psu_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .take          (s1_advance),
    .unpacked      (unpacked),
    .channel_count (chan_count),
    .spectrum_sum  (sum_value),
    .sum_done      (sum_done)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      sample_0     <= unpacked.s0;
      sample_1     <= unpacked.s1;
      sample_2     <= unpacked.s2;
      sample_3     <= unpacked.s3;
      sample_4     <= unpacked.s4;
      sample_5     <= unpacked.s5;
      sample_6     <= unpacked.s6;
      sample_7     <= unpacked.s7;
      sample_count <= unpacked.count;
      spectrum_sum <= sum_value;
      sum_ready    <= sum_done;
    end
  end

endmodule

// ===== src/psu_checker.sv =====
`include "packed_sample_unpack_channel_sum_unit_defines.svh"

module psu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic [3:0]                sample_1,
  input logic [1:0]                sample_2,
  input logic [1:0]                sample_3,
  input logic                      sample_4,
  input logic                      sample_5,
  input logic                      sample_6,
  input logic                      sample_7,
  input logic [psu_pkg::CNT_W-1:0] sample_count,
  input logic [psu_pkg::SUM_W-1:0] spectrum_sum,
  input logic                      sum_ready
);
  import psu_pkg::*;

  logic rest_zero;

  // All sample fields after the first are zero.
  assign rest_zero = (sample_1 == 4'd0) && (sample_2 == 2'd0) && (sample_3 == 2'd0) &&
                     !sample_4 && !sample_5 && !sample_6 && !sample_7;

  // Reset empties the result register.
  `PSU_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result beat valid after reset")

  // Sample count is always a single power of two.
  `PSU_ASSERT(a_count_onehot, out_valid |-> $onehot(sample_count), "bad sample count")

  // An 8-bit beat carries no other samples.
  `PSU_ASSERT(a_single_unused_zero, (out_valid && sample_count == CNT_W'(1)) |-> rest_zero, "unused sample field not zero")

  // Without a finished spectrum the sum field is zero.
  `PSU_ASSERT(a_sum_zero, (out_valid && !sum_ready) |-> spectrum_sum == '0, "spectrum sum shown without spectrum end")

endmodule

bind packed_sample_unpack_channel_sum_unit psu_checker u_psu_checker (.*);

// ===== tb/sample_sum_checker.sv =====
`timescale 1ns / 100ps

// Watches the input, result and register channels of the unpack unit,
// predicts every result beat and compares it with what the unit delivers.
module sample_sum_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    sample_0,
  input  logic [3:0]                    sample_1,
  input  logic [1:0]                    sample_2,
  input  logic [1:0]                    sample_3,
  input  logic                          sample_4,
  input  logic                          sample_5,
  input  logic                          sample_6,
  input  logic                          sample_7,
  input  logic [psu_pkg::CNT_W-1:0]     sample_count,
  input  logic [psu_pkg::SUM_W-1:0]     spectrum_sum,
  input  logic                          sum_ready,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psu_pkg::CH_W-1:0]      cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  import psu_pkg::*;

  localparam logic [SUM_W-1:0] SUM_CEILING  = '1;
  localparam int               REPORT_LIMIT = 10;

  // One result beat: unpacked samples, their count and the spectrum total.
  typedef struct packed {
    logic [7:0]       s0;
    logic [3:0]       s1;
    logic [1:0]       s2;
    logic [1:0]       s3;
    logic             s4;
    logic             s5;
    logic             s6;
    logic             s7;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic             done;
  } unpacked_byte_t;

  // Mirror of the register file and of the spectrum accumulator.
  logic [1:0]       width_code;
  logic [12:0]      channel_reg;
  logic [SUM_W-1:0] spectrum_acc;
  int               samples_taken;
  int               fail_total = 0;
  unpacked_byte_t   expected_q[$];

  // Splits one byte under the current width, adds its samples into the
  // spectrum total and closes the spectrum once the channel count is reached.
  function automatic unpacked_byte_t unpack_byte(input logic [7:0] b);
    unpacked_byte_t r;
    int             smp[8];
    int             n;
    int             total;
    int             limit;
    r     = '0;
    total = 0;
    for (int k = 0; k < 8; k++) smp[k] = 0;
    case (width_code)
      WIDTH_1BIT: begin
        n = 8;
        // One-bit samples come out inverted.
        for (int k = 0; k < 8; k++) smp[k] = b[7-k] ? 0 : 1;
      end
      WIDTH_2BIT: begin
        n = 4;
        for (int k = 0; k < 4; k++) smp[k] = int'(b >> (6 - 2 * k)) & 3;
      end
      WIDTH_4BIT: begin
        n      = 2;
        smp[0] = int'(b[7:4]);
        smp[1] = int'(b[3:0]);
      end
      default: begin
        n      = 1;
        smp[0] = int'(b);
      end
    endcase
    for (int k = 0; k < 8; k++) total += smp[k];

    // The accumulator saturates instead of wrapping.
    if (int'(spectrum_acc) + total > int'(SUM_CEILING)) spectrum_acc = SUM_CEILING;
    else spectrum_acc = SUM_W'(int'(spectrum_acc) + total);

    limit = (channel_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(channel_reg);
    samples_taken += n;

    r.s0    = 8'(smp[0]);
    r.s1    = 4'(smp[1]);
    r.s2    = 2'(smp[2]);
    r.s3    = 2'(smp[3]);
    r.s4    = 1'(smp[4]);
    r.s5    = 1'(smp[5]);
    r.s6    = 1'(smp[6]);
    r.s7    = 1'(smp[7]);
    r.count = CNT_W'(n);
    if (samples_taken >= limit) begin
      r.sum         = spectrum_acc;
      r.done        = 1'b1;
      spectrum_acc  = '0;
      samples_taken = 0;
    end
    return r;
  endfunction

  function automatic string beat_text(input unpacked_byte_t r);
    return $sformatf("samples %h %h %h %h %b%b%b%b count %0d sum %0d done %b",
                     r.s0, r.s1, r.s2, r.s3, r.s4, r.s5, r.s6, r.s7,
                     r.count, r.sum, r.done);
  endfunction

  always @(posedge clk) begin : watch
    unpacked_byte_t got;
    unpacked_byte_t want;
    if (rst) begin
      width_code    = SAMPLE_WIDTH_RESET;
      channel_reg   = CHANNEL_COUNT_RESET[12:0];
      spectrum_acc  = '0;
      samples_taken = 0;
      fail_total    = 0;
      expected_q.delete();
    end else begin
      // An input beat is predicted with the settings in force before this edge.
      if (in_valid && in_ready) expected_q.push_back(unpack_byte(data_byte));

      // Register writes; indexes outside the register file are dropped.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SAMPLE_WIDTH) width_code = cfg_data[1:0];
        else if (cfg_index == REG_CHANNEL_COUNT) channel_reg = cfg_data[12:0];
      end

      // A result beat is held against the oldest prediction.
      if (out_valid && out_ready) begin
        got = '{sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
                sample_6, sample_7, sample_count, spectrum_sum, sum_ready};
        if (expected_q.size() == 0) begin
          if (fail_total < REPORT_LIMIT)
            $display("%0t: result beat with nothing expected: %s", $realtime,
                     beat_text(got));
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_total < REPORT_LIMIT) begin
              $display("%0t: result beat mismatch", $realtime);
              $display("  expected %s", beat_text(want));
              $display("  actual   %s", beat_text(got));
            end
            fail_total++;
          end
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= expected_q.size();
  end

endmodule

// ===== tb/tb_packed_sample_unpack_channel_sum_unit.sv =====
`timescale 1ns / 100ps

// Drives bytes and register writes into the unpack unit, throttles the
// result side and gives the verdict from the checker's mismatch count.
module tb_packed_sample_unpack_channel_sum_unit;
  import psu_pkg::*;

  localparam int ITEM_TARGET  = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 80;

  // Register indexes that the unit must ignore.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 4'd15;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [7:0]           data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           sample_0;
  logic [3:0]           sample_1;
  logic [1:0]           sample_2;
  logic [1:0]           sample_3;
  logic                 sample_4;
  logic                 sample_5;
  logic                 sample_6;
  logic                 sample_7;
  logic [CNT_W-1:0]     sample_count;
  logic [SUM_W-1:0]     spectrum_sum;
  logic                 sum_ready;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CH_W-1:0]      cfg_data  = '0;

  int mismatch_count;
  int outstanding;
  int bytes_sent   = 0;
  int idle_cycles  = 0;
  int hold_left    = 0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  packed_sample_unpack_channel_sum_unit i_dut (.*);

  sample_sum_checker i_checker (
    .*,
    .mismatches (mismatch_count),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // Ends the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[packed_sample_unpack_channel_sum_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one byte, with random gaps ahead of it, and waits for its beat.
  // Valid is left high so that a following byte can go out back to back.
  task automatic send_byte(input logic [7:0] value);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Stops offering bytes and waits until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] code, input int channels);
    drain();
    write_reg(REG_SAMPLE_WIDTH, CH_W'(code));
    write_reg(REG_CHANNEL_COUNT, CH_W'(channels));
  endtask

  initial begin
    int         phase;
    int         nbytes;
    int         channels;
    int         per_byte;
    logic [1:0] code;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one 8-bit sample per byte, field extremes.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h5A);

    // Switch to one-bit samples mid-spectrum with a shorter spectrum:
    // the open spectrum closes with the very next byte.
    set_mode(WIDTH_1BIT, 8);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h01);

    // Channel count of zero closes a spectrum on every byte.
    set_mode(WIDTH_2BIT, 0);
    send_byte(8'hE4);
    send_byte(8'h1B);

    // Writes to unused indexes leave the settings alone.
    drain();
    write_reg(REG_UNUSED_LOW, CH_W'(3));
    write_reg(REG_UNUSED_HIGH, CH_W'(0));

    // A spectrum that ends inside a byte keeps all of that byte's samples.
    set_mode(WIDTH_2BIT, 10);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);

    // A channel count above the maximum is clamped.
    set_mode(WIDTH_4BIT, 8191);
    send_byte(8'hF0);
    send_byte(8'h0F);

    // Random phases: each with its own settings and random bytes.
    phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      code     = 2'($urandom_range(3));
      per_byte = 8 >> code;
      nbytes   = $urandom_range(20, 80);
      case ($urandom_range(9))
        0:       channels = 0;
        1:       channels = MAX_CHANNELS;
        2:       channels = $urandom_range(MAX_CHANNELS + 1, 8191);
        3:       channels = $urandom_range(1, 40);
        default: channels = per_byte * $urandom_range(1, 12);
      endcase
      // One full spectrum of the largest size in one-bit mode.
      if (phase == 4) begin
        code     = WIDTH_1BIT;
        channels = MAX_CHANNELS;
        nbytes   = 520;
      end
      if (phase == 7) nbytes = 150;

      drain();
      // Now and then the settings stay and the open spectrum carries on.
      if (phase == 4 || $urandom_range(5) != 0) begin
        write_reg(REG_SAMPLE_WIDTH, CH_W'(code));
        write_reg(REG_CHANNEL_COUNT, CH_W'(channels));
      end
      if ($urandom_range(5) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_HIGH)),
                  CH_W'($urandom_range(8191)));

      calm = (phase == 7);
      if (phase == 2) hold_request = 1'b1;
      for (int i = 0; i < nbytes; i++) send_byte(random_byte());
      bytes_sent += nbytes;
      phase++;
    end
    calm = 1'b0;

    drain();
    if (mismatch_count == 0) begin
      $display("[packed_sample_unpack_channel_sum_unit] OK");
    end else begin
      $display("[packed_sample_unpack_channel_sum_unit] ERROR");
    end
    $finish;
  end

endmodule
